// File: rtl/bso_pkg.sv
package bso_pkg;

  localparam int unsigned DefMaxDims = 8;
  localparam int unsigned WordW      = 32;
  localparam int unsigned DimIdxW    = 3;
  localparam int unsigned DimCntW    = 4;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    FUNC_LOAD    = 1'b0,
    FUNC_COMPUTE = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MOD,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    logic [WordW-1:0] out_index;
  } job_t;

  typedef struct packed {
    logic             busy;
    logic             res_valid;
  } back_status_t;

endpackage

// File: rtl/bso_divider.sv
module bso_divider (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [bso_pkg::WordW-1:0] dividend,
  input  logic [bso_pkg::WordW-1:0] divisor,
  output logic                     done,
  output logic [bso_pkg::WordW-1:0] quotient,
  output logic [bso_pkg::WordW-1:0] remainder
);

  localparam int unsigned W = bso_pkg::WordW;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    q_r, q_nxt;
  logic [W:0]      rem_r, rem_nxt;
  logic [W-1:0]    dvs_r, dvs_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            run_r, run_nxt;
  logic            done_r, done_nxt;
  logic [W:0]      trial;
  logic [W:0]      shifted;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[W-1:0], q_r[W-1]};
    trial    = shifted - {1'b0, dvs_r};
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CntW'(W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[W]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r[W-1:0];

endmodule

// File: rtl/bso_front.sv
module bso_front #(
  parameter int unsigned MAX_DIMS = bso_pkg::DefMaxDims
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        func,
  input  logic [bso_pkg::DimIdxW-1:0] dim_index,
  input  logic [bso_pkg::WordW-1:0]   out_extent,
  input  logic [bso_pkg::WordW-1:0]   out_stride,
  input  logic [bso_pkg::WordW-1:0]   first_stride,
  input  logic [bso_pkg::WordW-1:0]   second_stride,
  input  logic                        first_is_one,
  input  logic                        second_is_one,
  input  logic [bso_pkg::WordW-1:0]   out_index,
  input  logic                        back_busy,
  input  logic                        rd_en,
  input  logic [$clog2(MAX_DIMS+1)-1:0] rd_dim,
  output logic [bso_pkg::WordW-1:0]   rd_extent,
  output logic [bso_pkg::WordW-1:0]   rd_ostride,
  output logic [bso_pkg::WordW-1:0]   rd_fstride,
  output logic [bso_pkg::WordW-1:0]   rd_sstride,
  output logic                        rd_fskip,
  output logic                        rd_sskip,
  output logic                        q_valid,
  input  logic                        q_pop,
  output bso_pkg::job_t               q_head,
  output logic                        front_busy
);

  localparam int unsigned W    = bso_pkg::WordW;
  localparam int unsigned Dep  = bso_pkg::QueueDepth;
  localparam int unsigned PtrW = $clog2(Dep);
  localparam int unsigned TIdxW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic [W-1:0] ext_mem [MAX_DIMS];
  logic [W-1:0] ost_mem [MAX_DIMS];
  logic [W-1:0] fst_mem [MAX_DIMS];
  logic [W-1:0] sst_mem [MAX_DIMS];
  logic [MAX_DIMS-1:0] fsk_mem;
  logic [MAX_DIMS-1:0] ssk_mem;

  bso_pkg::job_t     qmem_r [Dep];
  logic [PtrW-1:0]   wp_r, rp_r;
  logic [PtrW:0]     cnt_r, cnt_nxt;
  logic              load_r;
  logic              acc, push, load;

  // Hold a load until no compute job is queued or being walked.
  assign in_ready = (func == bso_pkg::FUNC_COMPUTE) ? (cnt_r != (PtrW+1)'(Dep))
                                                    : ((cnt_r == '0) && !back_busy);
  assign acc  = in_valid && in_ready;
  assign push = acc && (func == bso_pkg::FUNC_COMPUTE);
  assign load = acc && (func == bso_pkg::FUNC_LOAD)
                && (32'(dim_index) < MAX_DIMS);

  // Table writes; reads registered for the back part.
  always_ff @(posedge clk) begin
    if (load) begin
      ext_mem[TIdxW'(dim_index)] <= out_extent;
      ost_mem[TIdxW'(dim_index)] <= out_stride;
      fst_mem[TIdxW'(dim_index)] <= first_stride;
      sst_mem[TIdxW'(dim_index)] <= second_stride;
      fsk_mem[TIdxW'(dim_index)] <= first_is_one;
      ssk_mem[TIdxW'(dim_index)] <= second_is_one;
    end
    if (rd_en) begin
      rd_extent  <= ext_mem[TIdxW'(rd_dim)];
      rd_ostride <= ost_mem[TIdxW'(rd_dim)];
      rd_fstride <= fst_mem[TIdxW'(rd_dim)];
      rd_sstride <= sst_mem[TIdxW'(rd_dim)];
      rd_fskip   <= fsk_mem[TIdxW'(rd_dim)];
      rd_sskip   <= ssk_mem[TIdxW'(rd_dim)];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && q_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) qmem_r[wp_r] <= '{out_index: out_index};
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
      load_r <= 1'b0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r  <= cnt_nxt;
      load_r <= load;
    end
  end

  assign q_valid    = (cnt_r != '0);
  assign q_head     = qmem_r[rp_r];
  assign front_busy = load_r;

endmodule

// File: rtl/bso_back.sv
module bso_back #(
  parameter int unsigned MAX_DIMS = bso_pkg::DefMaxDims
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bso_pkg::DimCntW-1:0]   dim_count,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  bso_pkg::job_t                 q_head,
  output logic                          rd_en,
  output logic [$clog2(MAX_DIMS+1)-1:0] rd_dim,
  input  logic [bso_pkg::WordW-1:0]     rd_extent,
  input  logic [bso_pkg::WordW-1:0]     rd_ostride,
  input  logic [bso_pkg::WordW-1:0]     rd_fstride,
  input  logic [bso_pkg::WordW-1:0]     rd_sstride,
  input  logic                          rd_fskip,
  input  logic                          rd_sskip,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bso_pkg::WordW-1:0]     first_offset,
  output logic [bso_pkg::WordW-1:0]     second_offset,
  output logic                          overflow,
  output bso_pkg::back_status_t         status
);

  localparam int unsigned W  = bso_pkg::WordW;
  localparam int unsigned DW = $clog2(MAX_DIMS+1);

  bso_pkg::back_state_t st_r, st_nxt;
  logic [W-1:0]   idx_r, idx_nxt;
  logic [DW-1:0]  k_r, k_nxt, n_r, n_nxt;
  logic [W-1:0]   off1_r, off1_nxt, off2_r, off2_nxt;
  logic           ovf_r, ovf_nxt;
  logic [W-1:0]   digit_r, digit_nxt;
  logic [2*W-1:0] p1_r, p1_nxt, p2_r, p2_nxt;
  logic           ov_r, ov_nxt;
  logic [W-1:0]   r1_r, r1_nxt, r2_r, r2_nxt;
  logic           rv_r, rv_nxt;
  logic           dstart;
  logic [W-1:0]   dnd, dvs;
  logic           ddone;
  logic [W-1:0]   dq, drem;
  logic [W:0]     s1, s2;
  logic           res_free;

  bso_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(dnd), .divisor(dvs),
    .done(ddone), .quotient(dq), .remainder(drem)
  );

  assign res_free = !rv_r || out_ready;
  assign s1 = {1'b0, off1_r} + {1'b0, p1_r[W-1:0]};
  assign s2 = {1'b0, off2_r} + {1'b0, p2_r[W-1:0]};
  // Read the row the walk moves to, so it is registered on entry to ST_DIV.
  assign rd_dim = k_nxt;

  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; k_nxt = k_r; n_nxt = n_r;
    off1_nxt = off1_r; off2_nxt = off2_r; ovf_nxt = ovf_r;
    digit_nxt = digit_r; p1_nxt = p1_r; p2_nxt = p2_r; ov_nxt = ov_r;
    r1_nxt = r1_r; r2_nxt = r2_r;
    rv_nxt = rv_r && !out_ready;
    q_pop = 1'b0; dstart = 1'b0; dnd = idx_r; dvs = rd_ostride; rd_en = 1'b0;
    case (st_r)
      bso_pkg::ST_IDLE: begin
        rd_en = 1'b1;
        if (q_valid) begin
          q_pop    = 1'b1;
          idx_nxt  = q_head.out_index;
          k_nxt    = '0;
          n_nxt    = (32'(dim_count) > MAX_DIMS) ? DW'(MAX_DIMS) : DW'(dim_count);
          off1_nxt = '0; off2_nxt = '0; ovf_nxt = 1'b0;
          st_nxt   = bso_pkg::ST_MUL;
          if (n_nxt == '0) st_nxt = bso_pkg::ST_DONE;
          else begin
            st_nxt = bso_pkg::ST_DIV;
            dstart = 1'b0;
          end
        end
      end
      bso_pkg::ST_DIV: begin
        // table row k is registered now; launch divide by the stride
        dnd = idx_r; dvs = rd_ostride;
        if (rd_ostride == '0 || rd_extent == '0) begin
          digit_nxt = '0;
          st_nxt    = bso_pkg::ST_MUL;
        end else begin
          dstart = 1'b1;
          st_nxt = bso_pkg::ST_MOD;
          ov_nxt = 1'b0;
        end
      end
      bso_pkg::ST_MOD: begin
        dnd = dq; dvs = rd_extent;
        if (ddone) begin
          if (!ov_r) begin
            dstart = 1'b1;
            ov_nxt = 1'b1;
          end else begin
            digit_nxt = drem;
            st_nxt    = bso_pkg::ST_MUL;
          end
        end
      end
      bso_pkg::ST_MUL: begin
        p1_nxt = rd_fskip ? '0 : digit_r * rd_fstride;
        p2_nxt = rd_sskip ? '0 : digit_r * rd_sstride;
        st_nxt = bso_pkg::ST_ACC;
      end
      bso_pkg::ST_ACC: begin
        off1_nxt = s1[W-1:0];
        off2_nxt = s2[W-1:0];
        ovf_nxt  = ovf_r || s1[W] || s2[W] || (p1_r[2*W-1:W] != '0)
                   || (p2_r[2*W-1:W] != '0);
        k_nxt    = k_r + 1'b1;
        rd_en    = 1'b1;
        st_nxt   = (k_nxt == n_r) ? bso_pkg::ST_DONE : bso_pkg::ST_DIV;
      end
      bso_pkg::ST_DONE: begin
        if (res_free) begin
          r1_nxt = off1_r; r2_nxt = off2_r;
          rv_nxt = 1'b1;
          st_nxt = bso_pkg::ST_IDLE;
        end
      end
      default: st_nxt = bso_pkg::ST_IDLE;
    endcase
  end

  // result flag kept apart from the divider phase flag
  logic resov_r, resov_nxt;
  always_comb begin
    resov_nxt = resov_r;
    if (st_r == bso_pkg::ST_DONE && res_free) resov_nxt = ovf_r;
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; n_r <= n_nxt; off1_r <= off1_nxt; off2_r <= off2_nxt;
    ovf_r <= ovf_nxt; digit_r <= digit_nxt; p1_r <= p1_nxt; p2_r <= p2_nxt;
    ov_r <= ov_nxt; r1_r <= r1_nxt; r2_r <= r2_nxt; resov_r <= resov_nxt;
    if (!rst_n) begin
      st_r <= bso_pkg::ST_IDLE;
      k_r  <= '0;
      rv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      k_r  <= k_nxt;
      rv_r <= rv_nxt;
    end
  end

  assign out_valid     = rv_r;
  assign first_offset  = r1_r;
  assign second_offset = r2_r;
  assign overflow      = resov_r;
  assign status        = '{busy: (st_r != bso_pkg::ST_IDLE), res_valid: rv_r};

endmodule

// File: rtl/broadcast_source_offsets_unit.sv
// Broadcast source offset unit.
// Input channel (in_valid/in_ready): a load transfer (func 0) writes one
// shape table entry and yields no result; a compute transfer (func 1)
// carries a flat output index and yields one result on the out_ channel.
// cfg_we/cfg_data set the dimension count; write it only while idle.
// A front part takes transfers, writes the table and queues compute jobs in
// a two-entry queue; a back part walks the dimensions one at a time.
// Each dimension costs two passes of the shared 32-step serial divider
// (quotient by the stride, then remainder by the extent), plus a divide
// launch, a multiply and an accumulate step; a dimension whose stride or
// extent is zero skips the divider. The back part walks one job at a time,
// so the divider sets the throughput. A load is held off while a compute
// job is queued or being walked. The result sits in an output register;
// when the receiver stalls it holds, the back part finishes the next job
// and waits, and the queue fills before in_ready drops.
// Reset (rst_n low, synchronous) clears the queue, the state machine and
// the dimension count; table entries stay undefined until loaded.
module broadcast_source_offsets_unit #(
  parameter int unsigned MAX_DIMS = bso_pkg::DefMaxDims
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bso_pkg::DimCntW-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_func,
  input  logic [bso_pkg::DimIdxW-1:0] in_dim_index,
  input  logic [bso_pkg::WordW-1:0]   in_out_extent,
  input  logic [bso_pkg::WordW-1:0]   in_out_stride,
  input  logic [bso_pkg::WordW-1:0]   in_first_stride,
  input  logic [bso_pkg::WordW-1:0]   in_second_stride,
  input  logic                        in_first_is_one,
  input  logic                        in_second_is_one,
  input  logic [bso_pkg::WordW-1:0]   in_out_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bso_pkg::WordW-1:0]   out_first_offset,
  output logic [bso_pkg::WordW-1:0]   out_second_offset,
  output logic                        out_overflow
);

  localparam int unsigned DW = $clog2(MAX_DIMS+1);

  logic [bso_pkg::DimCntW-1:0] dim_count_r;
  logic                        q_valid, q_pop, rd_en, front_busy;
  bso_pkg::job_t               q_head;
  logic [DW-1:0]               rd_dim;
  logic [bso_pkg::WordW-1:0]   rd_extent, rd_ostride, rd_fstride, rd_sstride;
  logic                        rd_fskip, rd_sskip;
  bso_pkg::back_status_t       status;

  // Hold the dimension count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r <= '0;
    end else if (cfg_we) begin
      dim_count_r <= cfg_data;
    end
  end

  bso_front #(.MAX_DIMS(MAX_DIMS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .func(in_func), .dim_index(in_dim_index), .out_extent(in_out_extent),
    .out_stride(in_out_stride), .first_stride(in_first_stride),
    .second_stride(in_second_stride), .first_is_one(in_first_is_one),
    .second_is_one(in_second_is_one), .out_index(in_out_index),
    .back_busy(status.busy),
    .rd_en(rd_en), .rd_dim(rd_dim), .rd_extent(rd_extent),
    .rd_ostride(rd_ostride), .rd_fstride(rd_fstride), .rd_sstride(rd_sstride),
    .rd_fskip(rd_fskip), .rd_sskip(rd_sskip), .q_valid(q_valid),
    .q_pop(q_pop), .q_head(q_head), .front_busy(front_busy)
  );

  bso_back #(.MAX_DIMS(MAX_DIMS)) u_back (
    .clk(clk), .rst_n(rst_n), .dim_count(dim_count_r), .q_valid(q_valid),
    .q_pop(q_pop), .q_head(q_head), .rd_en(rd_en), .rd_dim(rd_dim),
    .rd_extent(rd_extent), .rd_ostride(rd_ostride), .rd_fstride(rd_fstride),
    .rd_sstride(rd_sstride), .rd_fskip(rd_fskip), .rd_sskip(rd_sskip),
    .out_valid(out_valid), .out_ready(out_ready),
    .first_offset(out_first_offset), .second_offset(out_second_offset),
    .overflow(out_overflow), .status(status)
  );

  // A held result must not change before it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_first_offset)
      && $stable(out_second_offset) && $stable(out_overflow))
    else $error("held result changed");

  // The back part pops only when the queue holds a job.
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");

  // A fresh result appears only as the back part returns to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(status.res_valid) |-> !status.busy)
    else $error("result raised while busy");

  // A table write always comes from an accepted transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    front_busy |-> $past(in_valid && in_ready))
    else $error("load without transfer");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // One input transfer as seen on the in_ channel.
  typedef struct {
    bso_pkg::func_t func;
    logic [2:0]  dim;
    logic [31:0] extent;
    logic [31:0] ostride;
    logic [31:0] fstride;
    logic [31:0] sstride;
    logic        fskip;
    logic        sskip;
    logic [31:0] idx;
  } shape_op_t;

  // One offset pair expected on the out_ channel.
  typedef struct {
    logic [31:0] first;
    logic [31:0] second;
    logic        ovf;
  } offsets_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [bso_pkg::DimCntW-1:0]  cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_func;
  logic [bso_pkg::DimIdxW-1:0]  in_dim_index;
  logic [bso_pkg::WordW-1:0]    in_out_extent;
  logic [bso_pkg::WordW-1:0]    in_out_stride;
  logic [bso_pkg::WordW-1:0]    in_first_stride;
  logic [bso_pkg::WordW-1:0]    in_second_stride;
  logic                         in_first_is_one;
  logic                         in_second_is_one;
  logic [bso_pkg::WordW-1:0]    in_out_index;
  logic                         out_valid;
  logic                         out_ready;
  logic [bso_pkg::WordW-1:0]    out_first_offset;
  logic [bso_pkg::WordW-1:0]    out_second_offset;
  logic                         out_overflow;

  int unsigned mismatch_count = 0;
  bit          recv_no_stall  = 0;
  bit          send_no_gap    = 0;

  broadcast_source_offsets_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_dim_index      (in_dim_index),
    .in_out_extent     (in_out_extent),
    .in_out_stride     (in_out_stride),
    .in_first_stride   (in_first_stride),
    .in_second_stride  (in_second_stride),
    .in_first_is_one   (in_first_is_one),
    .in_second_is_one  (in_second_is_one),
    .in_out_index      (in_out_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_first_offset  (out_first_offset),
    .out_second_offset (out_second_offset),
    .out_overflow      (out_overflow)
  );

  // Print one line per mismatch and count it.
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got 0x%08h, want 0x%08h", $realtime, what, got, want);
  endtask

  // Shadow of the shape table plus the queue of offsets still owed.
  class OffsetScoreboard;
    logic [31:0] extent_tab [8];
    logic [31:0] ostride_tab[8];
    logic [31:0] fstride_tab[8];
    logic [31:0] sstride_tab[8];
    logic        fskip_tab  [8];
    logic        sskip_tab  [8];
    logic [3:0]  dims;
    offsets_t    pending_q[$];

    function new();
      dims = 0;
      foreach (extent_tab[k]) begin
        extent_tab[k] = 0; ostride_tab[k] = 0; fstride_tab[k] = 0;
        sstride_tab[k] = 0; fskip_tab[k] = 0; sskip_tab[k] = 0;
      end
    endfunction

    // Fold digit*stride into an offset, flag any carry past 32 bits.
    function logic [31:0] fold(logic [31:0] acc, logic [31:0] digit,
                               logic [31:0] stride, inout logic ovf);
      logic [63:0] prod;
      logic [32:0] sum;
      prod = {32'd0, digit} * {32'd0, stride};
      if (prod[63:32] != 0) ovf = 1'b1;
      sum = {1'b0, acc} + {1'b0, prod[31:0]};
      if (sum[32]) ovf = 1'b1;
      return sum[31:0];
    endfunction

    function void note_transfer(shape_op_t t);
      offsets_t    o;
      int unsigned n;
      logic [31:0] digit;
      if (t.func == bso_pkg::FUNC_LOAD) begin
        extent_tab[t.dim]  = t.extent;
        ostride_tab[t.dim] = t.ostride;
        fstride_tab[t.dim] = t.fstride;
        sstride_tab[t.dim] = t.sstride;
        fskip_tab[t.dim]   = t.fskip;
        sskip_tab[t.dim]   = t.sskip;
        return;
      end
      o.first = 0; o.second = 0; o.ovf = 0;
      n = (dims > 8) ? 8 : dims;
      for (int k = 0; k < n; k++) begin
        digit = 0;
        if (ostride_tab[k] != 0 && extent_tab[k] != 0)
          digit = (t.idx / ostride_tab[k]) % extent_tab[k];
        if (!fskip_tab[k]) o.first  = fold(o.first, digit, fstride_tab[k], o.ovf);
        if (!sskip_tab[k]) o.second = fold(o.second, digit, sstride_tab[k], o.ovf);
      end
      pending_q.push_back(o);
    endfunction

    task check_result(logic [31:0] first, logic [31:0] second, logic ovf);
      offsets_t o;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", first, 0);
        return;
      end
      o = pending_q.pop_front();
      if (first !== o.first)   report_mismatch("first_offset", first, o.first);
      if (second !== o.second) report_mismatch("second_offset", second, o.second);
      if (ovf !== o.ovf)       report_mismatch("overflow", ovf, o.ovf);
    endtask
  endclass

  OffsetScoreboard sb = new();

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // Receiver: sample the out_ channel before this edge's updates land, then
  // pick the next ready level. Stalls come in runs of random length.
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_first_offset, out_second_offset, out_overflow);
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!recv_no_stall && $urandom_range(0, 9) == 0) stall_left <= pick_gap();
    end
  end

  // Present one transfer and hold it until accepted; drop valid only when a
  // gap follows, so back-to-back transfers keep valid high.
  task automatic send_op(shape_op_t t);
    int unsigned gap;
    in_valid         <= 1'b1;
    in_func          <= t.func;
    in_dim_index     <= t.dim;
    in_out_extent    <= t.extent;
    in_out_stride    <= t.ostride;
    in_first_stride  <= t.fstride;
    in_second_stride <= t.sstride;
    in_first_is_one  <= t.fskip;
    in_second_is_one <= t.sskip;
    in_out_index     <= t.idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_transfer(t);
    gap = send_no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every owed result is back, then let any trailing load finish.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_dims(logic [3:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.dims = v;
  endtask

  function automatic shape_op_t load_op(logic [2:0] d, logic [31:0] ex, logic [31:0] os,
                                        logic [31:0] fs, logic [31:0] ss,
                                        logic f1, logic s1);
    shape_op_t t;
    t.func = bso_pkg::FUNC_LOAD; t.dim = d; t.extent = ex; t.ostride = os;
    t.fstride = fs; t.sstride = ss; t.fskip = f1; t.sskip = s1;
    t.idx = $urandom();
    return t;
  endfunction

  function automatic shape_op_t compute_op(logic [31:0] idx);
    shape_op_t t;
    t.func = bso_pkg::FUNC_COMPUTE; t.idx = idx;
    // Load fields carry noise; the block must ignore them.
    t.dim = 3'($urandom()); t.extent = $urandom(); t.ostride = $urandom();
    t.fstride = $urandom(); t.sstride = $urandom();
    t.fskip = 1'($urandom()); t.sskip = 1'($urandom());
    return t;
  endfunction

  // Word that is mostly small, sometimes full range, sometimes all ones.
  function automatic logic [31:0] shaped_word(logic [31:0] lo);
    int unsigned r;
    logic [31:0] w;
    r = $urandom_range(0, 9);
    if (r < 6)      w = $urandom_range(lo, 16);
    else if (r < 9) w = $urandom();
    else            w = 32'hFFFF_FFFF;
    if (w < lo) w = lo;
    return w;
  endfunction

  function automatic shape_op_t random_op();
    if ($urandom_range(0, 9) < 3)
      return load_op(3'($urandom()), shaped_word(1), shaped_word(1), shaped_word(0),
                     shaped_word(0), ($urandom_range(0, 3) == 0),
                     ($urandom_range(0, 3) == 0));
    return compute_op(($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 4095));
  endfunction

  // Dimension counts per random phase: mostly small, plus the extremes and
  // saturating values above the table size.
  logic [3:0] phase_dims[12] = '{1, 2, 8, 0, 3, 15, 1, 2, 9, 4, 1, 2};

  initial begin
    rst_n = 0; cfg_we = 0; cfg_data = 0; in_valid = 0; in_func = bso_pkg::FUNC_LOAD;
    in_dim_index = 0; in_out_extent = 1; in_out_stride = 1; in_first_stride = 0;
    in_second_stride = 0; in_first_is_one = 0; in_second_is_one = 0;
    in_out_index = 0; out_ready = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fill every entry first so no compute ever reads an unloaded one.
    send_op(load_op(0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
    send_op(load_op(1, 4, 1, 1, 2, 1, 0));
    send_op(load_op(2, 3, 4, 5, 6, 0, 1));
    send_op(load_op(3, 2, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 0));
    send_op(load_op(4, 7, 12, 0, 32'hFFFF_FFFF, 1, 1));
    send_op(load_op(5, 1, 3, 9, 10, 0, 0));
    send_op(load_op(6, 32'h0001_0000, 32'h0000_0100, 32'h0001_0001, 32'h7FFF_FFFF, 0, 0));
    send_op(load_op(7, 5, 32'h8000_0000, 3, 32'hFFFF_FFFF, 0, 0));
    write_dims(0);
    send_op(compute_op(32'hFFFF_FFFF));      // no dimensions: zero offsets
    write_dims(1);
    send_op(compute_op(0));
    send_op(compute_op(1));
    send_op(compute_op(32'hFFFF_FFFF));      // digit wraps to zero: zero offsets
    write_dims(8);
    send_op(compute_op(0));
    send_op(compute_op(32'hFFFF_FFFF));
    send_op(compute_op(32'h8000_0000));
    send_op(compute_op(32'h5A5A_A5A5));
    write_dims(15);                          // saturates to the table size
    send_op(compute_op(32'h1234_5678));
    send_op(compute_op(32'hFFFF_FFFE));

    // Random phases; some run with no idling at all on either side.
    for (int p = 0; p < 12; p++) begin
      write_dims(phase_dims[p]);
      send_no_gap   = (p % 4 == 1);
      recv_no_stall = (p % 4 == 1);
      for (int i = 0; i < 90; i++) begin
        send_op(random_op());
        // Hold the sender once until the block has fully caught up.
        if (p == 5 && i == 40) drain();
      end
    end
    send_no_gap = 0; recv_no_stall = 0;

    drain();
    if (mismatch_count == 0 && sb.pending_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
